// ===== rtl/core/positional_circular_list_engine_defines.svh =====
// Assertion macros used by the list engine datapath.
`ifndef POSITIONAL_CIRCULAR_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PCLE_CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PCLE_CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pcle_pkg.sv =====
package pcle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5,
        OP_READ_AT   = 3'd6,
        OP_FIND      = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // walk index control
    typedef enum logic [2:0] {
        IX_HOLD, IX_ZERO, IX_POS, IX_CNT_M1, IX_INC, IX_DEC
    } t_idx_cmd;

    // RAM write source
    typedef enum logic [2:0] {
        WR_NONE, WR_FRONT, WR_BACK, WR_POS, WR_UP, WR_REM
    } t_wr_cmd;

    // head / count update
    typedef enum logic [2:0] {
        UPD_NONE, UPD_INS_FRONT, UPD_INC, UPD_REM_FRONT, UPD_DEC
    } t_upd_cmd;

    typedef enum logic [1:0] {
        VS_HOLD, VS_RDATA, VS_VALUE
    } t_vsel;

    typedef enum logic [2:0] {
        IS_HOLD, IS_POS, IS_CNT, IS_IDX, IS_RIDX
    } t_isel;

    typedef struct packed {
        logic     load;
        logic     rd;
        t_idx_cmd idx;
        t_wr_cmd  wr;
        t_upd_cmd upd;
        logic     st_ld;
        t_status  st;
        t_vsel    vsel;
        t_isel    isel;
        logic     publish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic pos_gt;
        logic pos_ge;
        logic idx_eq_pos;
        logic idx_last;
        logic match;
        logic out_free;
    } t_sts;

    localparam t_cmd CMD_NOP = '{
        load:    1'b0,
        rd:      1'b0,
        idx:     IX_HOLD,
        wr:      WR_NONE,
        upd:     UPD_NONE,
        st_ld:   1'b0,
        st:      ST_OK,
        vsel:    VS_HOLD,
        isel:    IS_HOLD,
        publish: 1'b0
    };

endpackage

// ===== rtl/core/pcle_ram.sv =====
module pcle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pcle_datapath.sv =====
`include "positional_circular_list_engine_defines.svh"

module pcle_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcle_pkg::t_cmd                     i_cmd,
    output pcle_pkg::t_sts                     o_sts,
    input  logic [2:0]                         i_op,
    input  logic [pcle_pkg::POS_W-1:0]         i_position,
    input  logic signed [pcle_pkg::VAL_W-1:0]  i_value,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic signed [pcle_pkg::VAL_W-1:0]  o_value_out,
    output logic [pcle_pkg::IDX_W-1:0]         o_index_out,
    output logic [pcle_pkg::CNT_W-1:0]         o_count
);

    localparam int IDX_W = pcle_pkg::IDX_W;
    localparam int CNT_W = pcle_pkg::CNT_W;
    localparam int CMP_W = pcle_pkg::CMP_W;
    localparam int VAL_W = pcle_pkg::VAL_W;
    localparam int POS_W = pcle_pkg::POS_W;

    // ring slot of list index idx (idx never above CAPACITY)
    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(pcle_pkg::CAPACITY)) begin
            sum = sum - (CNT_W+1)'(pcle_pkg::CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]              r_op;
    logic [POS_W-1:0]        r_pos;
    logic [VAL_W-1:0]        r_val;
    logic [IDX_W-1:0]        r_head;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_ridx;
    pcle_pkg::t_status       r_st;
    logic [VAL_W-1:0]        r_vout;
    logic [IDX_W-1:0]        r_iout;
    logic                    r_out_valid;
    logic [2:0]              r_o_status;
    logic [VAL_W-1:0]        r_o_value;
    logic [IDX_W-1:0]        r_o_index;
    logic [CNT_W-1:0]        r_o_count;

    logic [VAL_W-1:0]        rdata;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [VAL_W-1:0]        wdata;
    logic [IDX_W-1:0]        raddr;
    logic [IDX_W-1:0]        head_m1;
    logic [IDX_W-1:0]        head_p1;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    ridx_is_pos;
    logic                    out_free;

    assign head_m1     = (r_head == '0) ? IDX_W'(pcle_pkg::CAPACITY - 1) : r_head - IDX_W'(1);
    assign head_p1     = (r_head == IDX_W'(pcle_pkg::CAPACITY - 1)) ? '0 : r_head + IDX_W'(1);
    assign cnt_m1      = r_cnt - CNT_W'(1);
    assign ridx_is_pos = (CMP_W'(r_ridx) == CMP_W'(r_pos));
    assign out_free    = !r_out_valid || !i_stall;
    assign raddr       = f_slot(r_head, CNT_W'(r_idx));

    // write port select; a removal shift drops the first word read (it is the result)
    always_comb begin
        we    = 1'b0;
        waddr = r_head;
        wdata = r_val;
        case (i_cmd.wr)
            pcle_pkg::WR_FRONT: begin
                we    = 1'b1;
                waddr = head_m1;
            end
            pcle_pkg::WR_BACK: begin
                we    = 1'b1;
                waddr = f_slot(r_head, r_cnt);
            end
            pcle_pkg::WR_POS: begin
                we    = 1'b1;
                waddr = f_slot(r_head, CNT_W'(r_pos));
            end
            pcle_pkg::WR_UP: begin
                we    = 1'b1;
                waddr = f_slot(r_head, CNT_W'(r_ridx) + CNT_W'(1));
                wdata = rdata;
            end
            pcle_pkg::WR_REM: begin
                we    = !ridx_is_pos;
                waddr = f_slot(r_head, CNT_W'(r_ridx) - CNT_W'(1));
                wdata = rdata;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    pcle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (pcle_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.upd)
                pcle_pkg::UPD_INS_FRONT: begin
                    r_head <= head_m1;
                    r_cnt  <= r_cnt + CNT_W'(1);
                end
                pcle_pkg::UPD_INC: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                pcle_pkg::UPD_REM_FRONT: begin
                    r_head <= (cnt_m1 == '0) ? '0 : head_p1;
                    r_cnt  <= cnt_m1;
                end
                pcle_pkg::UPD_DEC: begin
                    if (cnt_m1 == '0) begin
                        r_head <= '0;
                    end
                    r_cnt <= cnt_m1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_pos  <= i_position;
            r_val  <= i_value;
            r_st   <= pcle_pkg::ST_OK;
            r_vout <= '0;
            r_iout <= '0;
        end else begin
            if (i_cmd.st_ld) begin
                r_st <= i_cmd.st;
            end
            if (i_cmd.wr == pcle_pkg::WR_REM && ridx_is_pos) begin
                r_vout <= rdata;
            end else begin
                case (i_cmd.vsel)
                    pcle_pkg::VS_RDATA: r_vout <= rdata;
                    pcle_pkg::VS_VALUE: r_vout <= r_val;
                    default:            r_vout <= r_vout;
                endcase
            end
            case (i_cmd.isel)
                pcle_pkg::IS_POS:  r_iout <= IDX_W'(r_pos);
                pcle_pkg::IS_CNT:  r_iout <= IDX_W'(r_cnt);
                pcle_pkg::IS_IDX:  r_iout <= r_idx;
                pcle_pkg::IS_RIDX: r_iout <= r_ridx;
                default:           r_iout <= r_iout;
            endcase
        end
        case (i_cmd.idx)
            pcle_pkg::IX_ZERO:   r_idx <= '0;
            pcle_pkg::IX_POS:    r_idx <= IDX_W'(r_pos);
            pcle_pkg::IX_CNT_M1: r_idx <= cnt_m1[IDX_W-1:0];
            pcle_pkg::IX_INC:    r_idx <= r_idx + IDX_W'(1);
            pcle_pkg::IX_DEC:    r_idx <= r_idx - IDX_W'(1);
            default:             r_idx <= r_idx;
        endcase
        if (i_cmd.rd) begin
            r_ridx <= r_idx;
        end
        if (i_cmd.publish) begin
            r_o_status <= r_st;
            r_o_value  <= r_vout;
            r_o_index  <= r_iout;
            r_o_count  <= r_cnt;
        end
    end

    always_comb begin
        o_sts.op         = pcle_pkg::t_op'(r_op);
        o_sts.empty      = (r_cnt == '0);
        o_sts.full       = (r_cnt == CNT_W'(pcle_pkg::CAPACITY));
        o_sts.pos_gt     = (CMP_W'(r_pos) > CMP_W'(r_cnt));
        o_sts.pos_ge     = (CMP_W'(r_pos) >= CMP_W'(r_cnt));
        o_sts.idx_eq_pos = (CMP_W'(r_idx) == CMP_W'(r_pos));
        o_sts.idx_last   = (r_idx == cnt_m1[IDX_W-1:0]);
        o_sts.match      = (rdata == r_val);
        o_sts.out_free   = out_free;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_o_status;
    assign o_value_out = r_o_value;
    assign o_index_out = r_o_index;
    assign o_count     = r_o_count;

    `PCLE_CHK_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(pcle_pkg::CAPACITY), "count above capacity")
    `PCLE_CHK_NOW(a_head_home, i_clk, i_rst_n, r_cnt == '0, r_head == '0, "empty list with head off slot zero")
    `PCLE_CHK_NOW(a_ins_not_full, i_clk, i_rst_n, (i_cmd.wr == pcle_pkg::WR_FRONT || i_cmd.wr == pcle_pkg::WR_BACK || i_cmd.wr == pcle_pkg::WR_POS), r_cnt != CNT_W'(pcle_pkg::CAPACITY), "insert write into full list")
    `PCLE_CHK_NOW(a_rem_not_empty, i_clk, i_rst_n, (i_cmd.upd == pcle_pkg::UPD_DEC || i_cmd.upd == pcle_pkg::UPD_REM_FRONT), r_cnt != '0, "removal from empty list")
    `PCLE_CHK_NOW(a_publish_free, i_clk, i_rst_n, i_cmd.publish, out_free, "result overwrites pending output")
    `PCLE_CHK_NEXT(a_inc_nonzero, i_clk, i_rst_n, i_cmd.upd == pcle_pkg::UPD_INC, r_cnt != '0, "count zero after insert")

endmodule

// ===== rtl/core/pcle_ctrl.sv =====
module pcle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pcle_pkg::t_sts i_sts,
    output pcle_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_TAIL,
        S_INS_PUT,
        S_ONE_RD,
        S_ONE_GET,
        S_REM_SHIFT,
        S_REM_TAIL,
        S_FIND_SCAN,
        S_FIND_TAIL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_prime;   // set once the current walk has issued a RAM read
    logic   n_prime;

    always_comb begin
        n_state = r_state;
        n_prime = r_prime;
        o_cmd   = pcle_pkg::CMD_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_prime = 1'b0;
                n_state = S_DONE;
                case (i_sts.op)
                    pcle_pkg::OP_INS_FRONT: begin
                        if (i_sts.full) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr  = pcle_pkg::WR_FRONT;
                            o_cmd.upd = pcle_pkg::UPD_INS_FRONT;
                        end
                    end
                    pcle_pkg::OP_INS_BACK: begin
                        if (i_sts.full) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr   = pcle_pkg::WR_BACK;
                            o_cmd.isel = pcle_pkg::IS_CNT;
                            o_cmd.upd  = pcle_pkg::UPD_INC;
                        end
                    end
                    pcle_pkg::OP_INS_AT: begin
                        if (i_sts.full) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_FULL;
                        end else if (i_sts.pos_gt) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_RANGE;
                        end else if (i_sts.pos_ge) begin
                            // append: nothing to shift
                            o_cmd.wr   = pcle_pkg::WR_POS;
                            o_cmd.isel = pcle_pkg::IS_POS;
                            o_cmd.upd  = pcle_pkg::UPD_INC;
                        end else begin
                            o_cmd.idx  = pcle_pkg::IX_CNT_M1;
                            o_cmd.isel = pcle_pkg::IS_POS;
                            n_state    = S_INS_SHIFT;
                        end
                    end
                    pcle_pkg::OP_REM_FRONT, pcle_pkg::OP_REM_BACK: begin
                        if (i_sts.empty) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx = (i_sts.op == pcle_pkg::OP_REM_FRONT) ?
                                        pcle_pkg::IX_ZERO : pcle_pkg::IX_CNT_M1;
                            n_state   = S_ONE_RD;
                        end
                    end
                    pcle_pkg::OP_REM_AT: begin
                        if (i_sts.empty) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_EMPTY;
                        end else if (i_sts.pos_ge) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_RANGE;
                        end else begin
                            o_cmd.idx  = pcle_pkg::IX_POS;
                            o_cmd.isel = pcle_pkg::IS_POS;
                            n_state    = S_REM_SHIFT;
                        end
                    end
                    pcle_pkg::OP_READ_AT: begin
                        if (i_sts.empty) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_EMPTY;
                        end else if (i_sts.pos_ge) begin
                            o_cmd.st_ld = 1'b1;
                            o_cmd.st    = pcle_pkg::ST_RANGE;
                        end else begin
                            o_cmd.idx = pcle_pkg::IX_POS;
                            n_state   = S_ONE_RD;
                        end
                    end
                    default: begin
                        // find
                        o_cmd.st_ld = 1'b1;
                        if (i_sts.empty) begin
                            o_cmd.st = pcle_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.st  = pcle_pkg::ST_NOTFOUND;
                            o_cmd.idx = pcle_pkg::IX_ZERO;
                            n_state   = S_FIND_SCAN;
                        end
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // read the entry at the walk index while writing the word read last cycle one slot up
                o_cmd.rd = 1'b1;
                o_cmd.wr = r_prime ? pcle_pkg::WR_UP : pcle_pkg::WR_NONE;
                n_prime  = 1'b1;
                if (i_sts.idx_eq_pos) begin
                    n_state = S_INS_TAIL;
                end else begin
                    o_cmd.idx = pcle_pkg::IX_DEC;
                end
            end
            S_INS_TAIL: begin
                o_cmd.wr = pcle_pkg::WR_UP;
                n_state  = S_INS_PUT;
            end
            S_INS_PUT: begin
                o_cmd.wr  = pcle_pkg::WR_POS;
                o_cmd.upd = pcle_pkg::UPD_INC;
                n_state   = S_DONE;
            end
            S_ONE_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ONE_GET;
            end
            S_ONE_GET: begin
                o_cmd.vsel = pcle_pkg::VS_RDATA;
                o_cmd.isel = pcle_pkg::IS_IDX;
                case (i_sts.op)
                    pcle_pkg::OP_REM_FRONT: o_cmd.upd = pcle_pkg::UPD_REM_FRONT;
                    pcle_pkg::OP_REM_BACK:  o_cmd.upd = pcle_pkg::UPD_DEC;
                    default:                o_cmd.upd = pcle_pkg::UPD_NONE;
                endcase
                n_state = S_DONE;
            end
            S_REM_SHIFT: begin
                o_cmd.rd = 1'b1;
                o_cmd.wr = r_prime ? pcle_pkg::WR_REM : pcle_pkg::WR_NONE;
                n_prime  = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_REM_TAIL;
                end else begin
                    o_cmd.idx = pcle_pkg::IX_INC;
                end
            end
            S_REM_TAIL: begin
                o_cmd.wr  = pcle_pkg::WR_REM;
                o_cmd.upd = pcle_pkg::UPD_DEC;
                n_state   = S_DONE;
            end
            S_FIND_SCAN: begin
                if (r_prime && i_sts.match) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = pcle_pkg::ST_OK;
                    o_cmd.vsel  = pcle_pkg::VS_VALUE;
                    o_cmd.isel  = pcle_pkg::IS_RIDX;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_prime  = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_FIND_TAIL;
                    end else begin
                        o_cmd.idx = pcle_pkg::IX_INC;
                    end
                end
            end
            S_FIND_TAIL: begin
                if (i_sts.match) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = pcle_pkg::ST_OK;
                    o_cmd.vsel  = pcle_pkg::VS_VALUE;
                    o_cmd.isel  = pcle_pkg::IS_RIDX;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/core/positional_circular_list_engine.sv =====
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_op, i_position, i_value
// result    out        o_valid / i_stall   o_status, o_value_out, o_index_out, o_count
//
// One item in flight. A shifting insert or a remove at a position shifts the entries from the
// position to the tail, and a find scans from index zero until a hit or the end of the list:
// the list RAM (one read, one write port) moves one entry per cycle.
// Reset (synchronous, active low) empties the list; entries are never read before written.
// A stalled result waits in the output register while the next item is taken in.
module positional_circular_list_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_op,
    input  logic [pcle_pkg::POS_W-1:0]         i_position,
    input  logic signed [pcle_pkg::VAL_W-1:0]  i_value,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_status,
    output logic signed [pcle_pkg::VAL_W-1:0]  o_value_out,
    output logic [pcle_pkg::IDX_W-1:0]         o_index_out,
    output logic [pcle_pkg::CNT_W-1:0]         o_count
);

    // controller <-> datapath
    pcle_pkg::t_cmd cmd;
    pcle_pkg::t_sts sts;

    // Sequencer: decode, range checks, shift and scan loops, result hand-off.
    pcle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Ring RAM, head/count, walk index, result and output registers.
    pcle_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_index_out (o_index_out),
        .o_count     (o_count)
    );

endmodule
